/* design/ray_reflect_refract_generator_macros.svh */
// Assertion macros used by the checker file.
`ifndef RAY_REFLECT_REFRACT_GENERATOR_MACROS_SVH
`define RAY_REFLECT_REFRACT_GENERATOR_MACROS_SVH

// Checked only outside reset.
`define RRG_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrg check failed");

// Checked at every edge, reset included.
`define RRG_CHECK_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rrg reset check failed");

`endif

/* design/rrg_pkg.sv */
// Types, constants and helper functions of the secondary ray generator.
package rrg_pkg;

    localparam int NSTG      = 14;
    localparam int FRONT_STG = 5;
    localparam int SQ_STG    = 6;
    localparam int SQ_STEPS  = 4;
    localparam int BACK_STG  = 3;

    localparam int RAD_W  = 48;
    localparam int REM_W  = 26;
    localparam int ROOT_W = 24;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DEPTH   = 2'd1;
    localparam logic [1:0] ST_CONTRIB = 2'd2;
    localparam logic [1:0] ST_TIR     = 2'd3;

    localparam logic [1:0] CFG_MAX_DEPTH = 2'd0;
    localparam logic [1:0] CFG_MIN_CONTR = 2'd1;
    localparam logic [1:0] CFG_TIR_EPS   = 2'd2;

    localparam logic [3:0]  RST_MAX_DEPTH = 4'd4;
    localparam logic [15:0] RST_MIN_CONTR = 16'd1638;
    localparam logic [16:0] RST_TIR_EPS   = 17'd1;

    localparam logic [16:0] CONTRIB_MAX = 17'd32768;

    typedef struct packed {
        logic               op;
        logic signed [17:0] ix;
        logic signed [17:0] iy;
        logic signed [17:0] iz;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic [3:0]         depth;
        logic [15:0]        contrib;
        logic [15:0]        factor;
        logic [15:0]        n;
    } in_item_t;

    typedef struct packed {
        logic               op;
        logic [1:0]         status;
        logic [15:0]        contrib;
        logic [3:0]         depth;
        logic [15:0]        n;
        logic signed [17:0] ix;
        logic signed [17:0] iy;
        logic signed [17:0] iz;
        logic signed [18:0] nx;
        logic signed [18:0] ny;
        logic signed [18:0] nz;
    } ray_t;

    typedef struct packed {
        logic               op;
        logic [1:0]         status;
        logic [15:0]        contrib;
        logic [3:0]         depth;
        logic signed [18:0] nx;
        logic signed [18:0] ny;
        logic signed [18:0] nz;
        logic signed [21:0] drx;
        logic signed [21:0] dry;
        logic signed [21:0] drz;
        logic signed [21:0] nix;
        logic signed [21:0] niy;
        logic signed [21:0] niz;
        logic [22:0]        nc1s;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    function automatic logic signed [21:0] sat22(input logic signed [29:0] v);
        logic signed [21:0] r;
        if (v > 30'sd2097151)
            r = 22'sd2097151;
        else if (v < -30'sd2097152)
            r = -22'sd2097152;
        else
            r = v[21:0];
        return r;
    endfunction

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic sq_t sq_step(input sq_t a);
        sq_t              r;
        logic [REM_W-1:0] r4;
        logic [REM_W-1:0] trial;
        r4    = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
        trial = {a.root, 2'b01};
        r.rad = {a.rad[RAD_W-3:0], 2'b00};
        if (r4 >= trial)
        begin
            r.rem  = r4 - trial;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = r4;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* design/rrg_front.sv */
// Front pipeline: checks, dot product, c1, reflect direction, c2 and the radicand.
module rrg_front import rrg_pkg::*; (
    input  logic                 clk,
    input  logic [FRONT_STG-1:0] en,
    input  in_item_t             item,
    input  logic [3:0]           max_depth,
    input  logic [15:0]          min_contribution,
    input  logic [16:0]          tir_epsilon,
    output side_t                side,
    output logic [RAD_W-1:0]     rad
);

    // stage 1
    ray_t               s1_reg, s1_next;
    logic signed [35:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [31:0]        s1_cp_reg;
    logic [31:0]        s1_nn_reg;

    always_comb
    begin
        s1_next.op      = item.op;
        s1_next.status  = (item.depth > max_depth) ? ST_DEPTH : ST_OK;
        s1_next.contrib = '0;
        s1_next.depth   = (item.depth == 4'hF) ? 4'hF : item.depth + 4'd1;
        s1_next.n       = item.n;
        s1_next.ix      = item.ix;
        s1_next.iy      = item.iy;
        s1_next.iz      = item.iz;
        s1_next.nx      = 19'(item.nx);
        s1_next.ny      = 19'(item.ny);
        s1_next.nz      = 19'(item.nz);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg    <= s1_next;
            s1_px_reg <= item.ix * item.nx;
            s1_py_reg <= item.iy * item.ny;
            s1_pz_reg <= item.iz * item.nz;
            s1_cp_reg <= item.factor * item.contrib;
            s1_nn_reg <= item.n * item.n;
        end
    end

    // stage 2: c1 = floor(-dot / 2^16), folded to the positive side
    ray_t               s2_reg, s2_next;
    logic [19:0]        s2_c1_reg, s2_c1_next;
    logic [31:0]        s2_nn_reg;
    logic signed [37:0] dot, neg_dot;
    logic signed [21:0] c1raw;
    logic [15:0]        contrib_sat;

    always_comb
    begin
        dot     = 38'(s1_px_reg) + 38'(s1_py_reg) + 38'(s1_pz_reg);
        neg_dot = -dot;
        c1raw   = neg_dot[37:16];
        contrib_sat = (s1_cp_reg[31:15] > CONTRIB_MAX) ? CONTRIB_MAX[15:0] : s1_cp_reg[30:15];
        s2_next = s1_reg;
        s2_next.contrib = contrib_sat;
        if (s1_reg.status == ST_OK && contrib_sat < min_contribution)
            s2_next.status = ST_CONTRIB;
        if (c1raw[21])
        begin
            s2_c1_next = 20'(-c1raw);
            s2_next.nx = -s1_reg.nx;
            s2_next.ny = -s1_reg.ny;
            s2_next.nz = -s1_reg.nz;
        end
        else
        begin
            s2_c1_next = c1raw[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_reg    <= s2_next;
            s2_c1_reg <= s2_c1_next;
            s2_nn_reg <= s1_nn_reg;
        end
    end

    // stage 3: products of c1
    ray_t               s3_reg;
    logic [39:0]        s3_c1c1_reg;
    logic [35:0]        s3_nc1_reg;
    logic [31:0]        s3_nn_reg;
    logic signed [34:0] s3_nix_reg, s3_niy_reg, s3_niz_reg;
    logic signed [39:0] s3_rcx_reg, s3_rcy_reg, s3_rcz_reg;
    logic signed [20:0] c1s;
    logic signed [16:0] ns;

    always_comb
    begin
        c1s = $signed({1'b0, s2_c1_reg});
        ns  = $signed({1'b0, s2_reg.n});
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_reg      <= s2_reg;
            s3_nn_reg   <= s2_nn_reg;
            s3_c1c1_reg <= s2_c1_reg * s2_c1_reg;
            s3_nc1_reg  <= s2_reg.n * s2_c1_reg;
            s3_nix_reg  <= ns * s2_reg.ix;
            s3_niy_reg  <= ns * s2_reg.iy;
            s3_niz_reg  <= ns * s2_reg.iz;
            s3_rcx_reg  <= c1s * s2_reg.nx;
            s3_rcy_reg  <= c1s * s2_reg.ny;
            s3_rcz_reg  <= c1s * s2_reg.nz;
        end
    end

    // stage 4: n^2 * (1 - c1^2), reflect direction
    side_t              s4_reg, s4_next;
    logic signed [57:0] s4_nnt_reg;
    logic [23:0]        c1sq;
    logic signed [24:0] t;

    always_comb
    begin
        c1sq = s3_c1c1_reg[39:16];
        t    = 25'sd65536 - $signed({1'b0, c1sq});
        s4_next.op      = s3_reg.op;
        s4_next.status  = s3_reg.status;
        s4_next.contrib = s3_reg.contrib;
        s4_next.depth   = s3_reg.depth;
        s4_next.nx      = s3_reg.nx;
        s4_next.ny      = s3_reg.ny;
        s4_next.nz      = s3_reg.nz;
        s4_next.drx     = sat22(30'(s3_reg.ix) + 30'(s3_rcx_reg >>> 15));
        s4_next.dry     = sat22(30'(s3_reg.iy) + 30'(s3_rcy_reg >>> 15));
        s4_next.drz     = sat22(30'(s3_reg.iz) + 30'(s3_rcz_reg >>> 15));
        s4_next.nix     = 22'(s3_nix_reg >>> 13);
        s4_next.niy     = 22'(s3_niy_reg >>> 13);
        s4_next.niz     = 22'(s3_niz_reg >>> 13);
        s4_next.nc1s    = s3_nc1_reg[35:13];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_reg     <= s4_next;
            s4_nnt_reg <= $signed({1'b0, s3_nn_reg}) * t;
        end
    end

    // stage 5: c2 and the total internal reflection check
    side_t              s5_reg, s5_next;
    logic [RAD_W-1:0]   s5_rad_reg;
    logic signed [33:0] c2;

    always_comb
    begin
        c2      = 34'sd65536 - 34'(s4_nnt_reg >>> 26);
        s5_next = s4_reg;
        if (s4_reg.op && s4_reg.status == ST_OK && c2 < $signed({17'd0, tir_epsilon}))
            s5_next.status = ST_TIR;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_reg     <= s5_next;
            s5_rad_reg <= {2'b00, c2[29:0], 16'd0};
        end
    end

    assign side = s5_reg;
    assign rad  = s5_rad_reg;

endmodule

/* design/rrg_sqrt.sv */
// Pipelined restoring square root, SQ_STEPS root bits per stage; side data rides along.
module rrg_sqrt import rrg_pkg::*; (
    input  logic               clk,
    input  logic [SQ_STG-1:0]  en,
    input  side_t              side_in,
    input  logic [RAD_W-1:0]   rad,
    output side_t              side_out,
    output logic [ROOT_W-1:0]  root
);

    side_t side_reg [SQ_STG];
    sq_t   sq_reg   [SQ_STG];
    sq_t   sq_next  [SQ_STG];

    always_comb
    begin
        sq_t a;
        a.rad  = rad;
        a.rem  = '0;
        a.root = '0;
        for (int k = 0; k < SQ_STEPS; k++)
            a = sq_step(a);
        sq_next[0] = a;
        for (int s = 1; s < SQ_STG; s++)
        begin
            a = sq_reg[s-1];
            for (int k = 0; k < SQ_STEPS; k++)
                a = sq_step(a);
            sq_next[s] = a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_reg[0]   <= sq_next[0];
            side_reg[0] <= side_in;
        end
        for (int s = 1; s < SQ_STG; s++)
        begin
            if (en[s])
            begin
                sq_reg[s]   <= sq_next[s];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign side_out = side_reg[SQ_STG-1];
    assign root     = sq_reg[SQ_STG-1].root;

endmodule

/* design/rrg_back.sv */
// Back pipeline: refract scale k, k*N, final sum, selection and output register.
module rrg_back import rrg_pkg::*; (
    input  logic                clk,
    input  logic [BACK_STG-1:0] en,
    input  side_t               side,
    input  logic [ROOT_W-1:0]   root,
    output logic [1:0]          status,
    output logic signed [21:0]  out_dir_x,
    output logic signed [21:0]  out_dir_y,
    output logic signed [21:0]  out_dir_z,
    output logic [15:0]         out_contribution,
    output logic [3:0]          out_depth
);

    side_t              a_reg;
    logic signed [24:0] a_k_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg   <= side;
            a_k_reg <= $signed({2'b00, side.nc1s}) - $signed({1'b0, root});
        end
    end

    side_t              b_reg;
    logic signed [43:0] b_knx_reg, b_kny_reg, b_knz_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_reg     <= a_reg;
            b_knx_reg <= a_k_reg * a_reg.nx;
            b_kny_reg <= a_k_reg * a_reg.ny;
            b_knz_reg <= a_k_reg * a_reg.nz;
        end
    end

    logic [1:0]         status_reg, status_next;
    logic signed [21:0] dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic [15:0]        contrib_reg, contrib_next;
    logic [3:0]         depth_reg, depth_next;

    always_comb
    begin
        status_next = b_reg.status;
        if (b_reg.status != ST_OK)
        begin
            dx_next      = '0;
            dy_next      = '0;
            dz_next      = '0;
            contrib_next = '0;
            depth_next   = '0;
        end
        else
        begin
            contrib_next = b_reg.contrib;
            depth_next   = b_reg.depth;
            if (b_reg.op)
            begin
                dx_next = sat22(30'(b_reg.nix) + 30'(b_knx_reg >>> 16));
                dy_next = sat22(30'(b_reg.niy) + 30'(b_kny_reg >>> 16));
                dz_next = sat22(30'(b_reg.niz) + 30'(b_knz_reg >>> 16));
            end
            else
            begin
                dx_next = b_reg.drx;
                dy_next = b_reg.dry;
                dz_next = b_reg.drz;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            status_reg  <= status_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            dz_reg      <= dz_next;
            contrib_reg <= contrib_next;
            depth_reg   <= depth_next;
        end
    end

    assign status           = status_reg;
    assign out_dir_x        = dx_reg;
    assign out_dir_y        = dy_reg;
    assign out_dir_z        = dz_reg;
    assign out_contribution = contrib_reg;
    assign out_depth        = depth_reg;

endmodule

/* design/ray_reflect_refract_generator.sv */
// The pipeline runs the front, square root and back stages from input beat to output beat.
// Throughput: one beat per cycle unless out_ready stalls the output; each stage has its own
// valid bit and advances whenever it is empty or the stage after it advances, so bubbles are squeezed out.
// The square root resolves 4 root bits per stage over 6 stages.
// Reset clears all valid bits and loads the configuration register defaults.
// Top level of the secondary ray generator.
module ray_reflect_refract_generator import rrg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [17:0] in_dir_x,
    input  logic signed [17:0] in_dir_y,
    input  logic signed [17:0] in_dir_z,
    input  logic signed [17:0] norm_x,
    input  logic signed [17:0] norm_y,
    input  logic signed [17:0] norm_z,
    input  logic [3:0]         in_depth,
    input  logic [15:0]        in_contribution,
    input  logic [15:0]        factor,
    input  logic [15:0]        refr_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [21:0] out_dir_x,
    output logic signed [21:0] out_dir_y,
    output logic signed [21:0] out_dir_z,
    output logic [15:0]        out_contribution,
    output logic [3:0]         out_depth
);

    logic [3:0]  max_depth_reg;
    logic [15:0] min_contr_reg;
    logic [16:0] tir_eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= RST_MAX_DEPTH;
            min_contr_reg <= RST_MIN_CONTR;
            tir_eps_reg   <= RST_TIR_EPS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_DEPTH: max_depth_reg <= cfg_data[3:0];
                CFG_MIN_CONTR: min_contr_reg <= cfg_data[15:0];
                CFG_TIR_EPS:   tir_eps_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // valid bits and per-stage advance
    logic [NSTG-1:0] v_reg, v_next;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
        v_next = v_reg;
        if (en[0])
            v_next[0] = in_valid;
        for (int i = 1; i < NSTG; i++)
        begin
            if (en[i])
                v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    in_item_t         item;
    side_t            front_side, sq_side;
    logic [RAD_W-1:0] rad;
    logic [ROOT_W-1:0] root;

    always_comb
    begin
        item.op      = op;
        item.ix      = in_dir_x;
        item.iy      = in_dir_y;
        item.iz      = in_dir_z;
        item.nx      = norm_x;
        item.ny      = norm_y;
        item.nz      = norm_z;
        item.depth   = in_depth;
        item.contrib = in_contribution;
        item.factor  = factor;
        item.n       = refr_index;
    end

    rrg_front u_front (
        .clk              (clk),
        .en               (en[FRONT_STG-1:0]),
        .item             (item),
        .max_depth        (max_depth_reg),
        .min_contribution (min_contr_reg),
        .tir_epsilon      (tir_eps_reg),
        .side             (front_side),
        .rad              (rad)
    );

    rrg_sqrt u_sqrt (
        .clk      (clk),
        .en       (en[FRONT_STG+SQ_STG-1:FRONT_STG]),
        .side_in  (front_side),
        .rad      (rad),
        .side_out (sq_side),
        .root     (root)
    );

    rrg_back u_back (
        .clk              (clk),
        .en               (en[NSTG-1:FRONT_STG+SQ_STG]),
        .side             (sq_side),
        .root             (root),
        .status           (status),
        .out_dir_x        (out_dir_x),
        .out_dir_y        (out_dir_y),
        .out_dir_z        (out_dir_z),
        .out_contribution (out_contribution),
        .out_depth        (out_depth)
    );

endmodule

/* design/rrg_checker.sv */
// Port-level checker for the secondary ray generator, bound to the top level.
`include "ray_reflect_refract_generator_macros.svh"

module rrg_checker import rrg_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [21:0] out_dir_x,
    input logic signed [21:0] out_dir_y,
    input logic signed [21:0] out_dir_z,
    input logic [15:0]        out_contribution,
    input logic [3:0]         out_depth
);

    `RRG_CHECK_RST(a_no_beat_in_reset, !rst_n |-> !out_valid)

    `RRG_CHECK(a_out_held, out_valid && !out_ready |=> out_valid)

    `RRG_CHECK(a_reject_zero, out_valid && status != ST_OK |-> out_dir_x == 0 && out_dir_y == 0 && out_dir_z == 0 && out_contribution == 0 && out_depth == 0)

    `RRG_CHECK(a_ray_depth, out_valid && status == ST_OK |-> out_depth != 0 && out_contribution <= 16'd32768)

endmodule

bind ray_reflect_refract_generator rrg_checker u_rrg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .out_dir_x        (out_dir_x),
    .out_dir_y        (out_dir_y),
    .out_dir_z        (out_dir_z),
    .out_contribution (out_contribution),
    .out_depth        (out_depth)
);
